FILE: rtl/core/wsts_pkg.sv
// Shared types and constants of the weighted sum-tree sampler.
`default_nettype none
package wsts_pkg;

   localparam int MAX_ENTRIES    = 1024;
   localparam int IDX_W          = 10;
   localparam int CNT_W          = 11;
   localparam int WEIGHT_BITS    = 32;
   localparam int PROB_FRAC_BITS = 16;
   localparam int TOT_W          = 42;
   localparam int MUL_A_W        = 16;
   localparam int MUL_B_W        = TOT_W + 1;
   localparam int PROD_W         = MUL_A_W + MUL_B_W;
   localparam int DIV_NUM_W      = TOT_W + PROB_FRAC_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_NUM_W);

   localparam logic [WEIGHT_BITS-1:0]    WMAX = '1;
   localparam logic [PROB_FRAC_BITS-1:0] PMAX = '1;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_PROJECT = 2'd1;
   localparam logic [1:0] KIND_SAMPLE  = 2'd2;
   localparam logic [1:0] KIND_QUERY   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN = 2'd2;

   localparam logic CSR_NUM_ENTRIES = 1'b0;
   localparam logic CSR_MIN_PROB    = 1'b1;

   typedef struct packed {
      logic [1:0]                kind;
      logic [IDX_W-1:0]          entry_index;
      logic [31:0]               weight;
      logic [15:0]               target_prob;
      logic [15:0]               random_fraction;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] chosen_index;
      logic [15:0]      probability;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]       w_raddr;
      logic                   w_we;
      logic [IDX_W-1:0]       w_waddr;
      logic [WEIGHT_BITS-1:0] w_wdata;
      logic [IDX_W-1:0]       t_raddr;
      logic                   t_we;
      logic [IDX_W-1:0]       t_waddr;
      logic [TOT_W-1:0]       t_wdata;
   } store_cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [TOT_W-1:0]     den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/weighted_sum_tree_sampler_core.sv
// Load and project update the totals from the entry up to the root, a sample walks
// down from the root, and query and the min_prob branch of project use the divider.
// One word in flight at a time; the tree walk through the memories and the bit-serial
// divider set the pace. Results wait in an output register.
// Reset (and any num_entries write) runs a clearing pass over all 1024 entries of both
// memories; req_ready stays low during it, CSR writes are still taken.
`default_nettype none
module weighted_sum_tree_sampler_core
   import wsts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_WRD, S_SETW, S_URD, S_UWR,
      S_SMUL1, S_SMUL2, S_SWALK, S_SCHK,
      S_PM1, S_PM2, S_PM3, S_PM4, S_PM5, S_PM6, S_PDIV,
      S_QDIV, S_RESP
   } state_type;

   state_type              state_ff;
   logic [IDX_W-1:0]       clr_ff;
   logic [CNT_W-1:0]       num_entries_ff;
   logic [15:0]            min_prob_ff;
   logic [TOT_W-1:0]       mass_ff;
   req_type                req_ff;
   rsp_type                res_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   logic [IDX_W-1:0]       node_ff;
   logic [WEIGHT_BITS-1:0] wold_ff;
   logic [WEIGHT_BITS-1:0] nw_ff;
   logic [TOT_W-1:0]       delta_ff;
   logic [TOT_W-1:0]       rest_ff;
   logic [TOT_W-1:0]       p_ff;
   logic [TOT_W-1:0]       coin_ff;
   logic                   ovr_ff;
   logic [MUL_A_W-1:0]     mul_a_ff;
   logic [MUL_B_W-1:0]     mul_b_ff;
   logic [PROD_W-1:0]      prod_ff;
   div_req_type            div_req_ff;
   div_rsp_type            div_rsp;
   store_cmd_type          cmd;
   logic [WEIGHT_BITS-1:0] w_rdata;
   logic [TOT_W-1:0]       t_rdata;

   logic [CNT_W-1:0]       n_eff;
   logic [CNT_W-1:0]       left_idx;
   logic [CNT_W:0]         right_idx;
   logic [TOT_W-1:0]       t_new;
   logic [TOT_W:0]         wl;
   logic [TOT_W:0]         z;
   logic [IDX_W-1:0]       node_m1;
   logic                   csr_clear;
   logic                   rsp_load;

   wsts_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .w_rdata (w_rdata),
      .t_rdata (t_rdata)
   );

   wsts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   // Zero acts as one entry, anything past the store acts as a full store.
   always_comb begin
      if (num_entries_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (num_entries_ff > CNT_W'(MAX_ENTRIES)) begin
         n_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         n_eff = num_entries_ff;
      end
   end

   always_comb begin
      left_idx  = {node_ff, 1'b1};
      right_idx = {1'b0, node_ff, 1'b0} + (CNT_W+1)'(2);
      t_new     = t_rdata + delta_ff;
      wl        = {{(TOT_W+1-WEIGHT_BITS){1'b0}}, w_rdata} + {1'b0, t_rdata};
      z         = {1'b0, rest_ff} + {1'b0, prod_ff[PROD_W-2:PROB_FRAC_BITS]};
      node_m1   = node_ff - 1'b1;
   end

   // A new entry count takes priority over the sequencer; the output register
   // loads when a finished result finds it free.
   always_comb begin
      csr_clear = csr_we && (csr_index == CSR_NUM_ENTRIES);
      rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready) && !csr_clear;
   end

   // Memory port steering: each read is issued in the state before the one that
   // consumes it; a read that meets a write to the same entry is never consumed.
   always_comb begin
      cmd         = '0;
      cmd.w_raddr = (state_ff == S_IDLE) ? req_data.entry_index : node_ff;
      cmd.t_raddr = (state_ff == S_SWALK) ? left_idx[IDX_W-1:0] : node_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.w_we    = 1'b1;
            cmd.w_waddr = clr_ff;
            cmd.t_we    = 1'b1;
            cmd.t_waddr = clr_ff;
         end
         S_SETW: begin
            cmd.w_we    = 1'b1;
            cmd.w_waddr = req_ff.entry_index;
            cmd.w_wdata = nw_ff;
         end
         S_UWR: begin
            cmd.t_we    = 1'b1;
            cmd.t_waddr = node_ff;
            cmd.t_wdata = t_new;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         num_entries_ff <= CNT_W'(MAX_ENTRIES);
         min_prob_ff    <= '0;
         mass_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         div_req_ff     <= '0;
      end else begin
         // Kick the divider for a query or for the min_prob branch of project.
         div_req_ff.start <= ((state_ff == S_WRD) && (req_ff.kind == KIND_QUERY)) ||
                             (state_ff == S_PM6);
         prod_ff <= PROD_W'(mul_a_ff) * PROD_W'(mul_b_ff);

         // Hold the result until the output register is free.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res_ff;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we && (csr_index == CSR_MIN_PROB)) begin
            min_prob_ff <= csr_wdata;
         end

         // A new entry count empties the tree: restart the clearing pass.
         if (csr_clear) begin
            num_entries_ff <= csr_wdata[CNT_W-1:0];
            mass_ff        <= '0;
            clr_ff         <= '0;
            state_ff       <= S_CLEAR;
         end else begin
            case (state_ff)
               S_CLEAR: begin
                  clr_ff <= clr_ff + 1'b1;
                  if (clr_ff == IDX_W'(MAX_ENTRIES - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end

               S_IDLE: begin
                  if (req_valid) begin
                     req_ff <= req_data;
                     if (req_data.kind == KIND_SAMPLE) begin
                        if (mass_ff == '0) begin
                           res_ff   <= '{chosen_index: '0, probability: '0,
                                         status: STATUS_OVERRUN};
                           state_ff <= S_RESP;
                        end else begin
                           mul_a_ff <= req_data.random_fraction;
                           mul_b_ff <= {1'b0, mass_ff};
                           state_ff <= S_SMUL1;
                        end
                     end else if ({1'b0, req_data.entry_index} >= n_eff) begin
                        res_ff   <= '{chosen_index: req_data.entry_index, probability: '0,
                                      status: STATUS_RANGE};
                        state_ff <= S_RESP;
                     end else if (req_data.kind == KIND_QUERY && mass_ff == '0) begin
                        res_ff   <= '{chosen_index: req_data.entry_index, probability: '0,
                                      status: STATUS_OK};
                        state_ff <= S_RESP;
                     end else begin
                        state_ff <= S_WRD;
                     end
                  end
               end

               // Old weight of the addressed entry is on the read port.
               S_WRD: begin
                  wold_ff <= w_rdata;
                  case (req_ff.kind)
                     KIND_LOAD: begin
                        nw_ff    <= req_ff.weight;
                        state_ff <= S_SETW;
                     end
                     KIND_PROJECT: begin
                        mul_a_ff <= req_ff.target_prob;
                        mul_b_ff <= {1'b0, mass_ff};
                        rest_ff  <= (mass_ff >= TOT_W'(w_rdata)) ?
                                    mass_ff - TOT_W'(w_rdata) : '0;
                        state_ff <= S_PM1;
                     end
                     KIND_QUERY: begin
                        div_req_ff.num <= DIV_NUM_W'({w_rdata, {PROB_FRAC_BITS{1'b0}}});
                        div_req_ff.den <= mass_ff;
                        state_ff       <= S_QDIV;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end

               // Write the new weight, then push the difference up to the root.
               S_SETW: begin
                  delta_ff <= TOT_W'(nw_ff) - TOT_W'(wold_ff);
                  node_ff  <= req_ff.entry_index;
                  state_ff <= S_URD;
               end

               S_URD: begin
                  state_ff <= S_UWR;
               end

               S_UWR: begin
                  if (node_ff == '0) begin
                     mass_ff  <= t_new;
                     res_ff   <= '{chosen_index: req_ff.entry_index, probability: '0,
                                   status: STATUS_OK};
                     state_ff <= S_RESP;
                  end else begin
                     node_ff  <= {1'b0, node_m1[IDX_W-1:1]};
                     state_ff <= S_URD;
                  end
               end

               S_SMUL1: begin
                  state_ff <= S_SMUL2;
               end

               S_SMUL2: begin
                  coin_ff  <= prod_ff[PROD_W-2:PROB_FRAC_BITS];
                  node_ff  <= '0;
                  ovr_ff   <= 1'b0;
                  state_ff <= S_SWALK;
               end

               S_SWALK: begin
                  if (left_idx < n_eff) begin
                     state_ff <= S_SCHK;
                  end else begin
                     res_ff   <= '{chosen_index: node_ff, probability: '0,
                                   status: ovr_ff ? STATUS_OVERRUN : STATUS_OK};
                     state_ff <= S_RESP;
                  end
               end

               // Stop here, go left, or go right (fall back left past the last node).
               S_SCHK: begin
                  if (coin_ff < TOT_W'(w_rdata)) begin
                     res_ff   <= '{chosen_index: node_ff, probability: '0,
                                   status: ovr_ff ? STATUS_OVERRUN : STATUS_OK};
                     state_ff <= S_RESP;
                  end else if ({1'b0, coin_ff} < wl) begin
                     coin_ff  <= coin_ff - TOT_W'(w_rdata);
                     node_ff  <= left_idx[IDX_W-1:0];
                     state_ff <= S_SWALK;
                  end else begin
                     coin_ff <= coin_ff - wl[TOT_W-1:0];
                     if (right_idx < {1'b0, n_eff}) begin
                        node_ff <= right_idx[IDX_W-1:0];
                     end else begin
                        ovr_ff  <= 1'b1;
                        node_ff <= left_idx[IDX_W-1:0];
                     end
                     state_ff <= S_SWALK;
                  end
               end

               S_PM1: begin
                  state_ff <= S_PM2;
               end

               // p = target * M >> F; next form min_prob * (rest + p).
               S_PM2: begin
                  p_ff     <= prod_ff[PROD_W-2:PROB_FRAC_BITS];
                  mul_a_ff <= min_prob_ff;
                  mul_b_ff <= z;
                  state_ff <= S_PM3;
               end

               S_PM3: begin
                  state_ff <= S_PM4;
               end

               S_PM4: begin
                  if ({1'b0, p_ff, {PROB_FRAC_BITS{1'b0}}} >= prod_ff) begin
                     nw_ff    <= (|p_ff[TOT_W-1:WEIGHT_BITS]) ? WMAX :
                                 p_ff[WEIGHT_BITS-1:0];
                     state_ff <= S_SETW;
                  end else begin
                     mul_a_ff <= min_prob_ff;
                     mul_b_ff <= {1'b0, rest_ff};
                     state_ff <= S_PM5;
                  end
               end

               S_PM5: begin
                  state_ff <= S_PM6;
               end

               S_PM6: begin
                  div_req_ff.num <= prod_ff[DIV_NUM_W-1:0];
                  div_req_ff.den <= TOT_W'({1'b1, {PROB_FRAC_BITS{1'b0}}}) -
                                    TOT_W'(min_prob_ff);
                  state_ff       <= S_PDIV;
               end

               S_PDIV: begin
                  if (div_rsp.done) begin
                     nw_ff    <= (|div_rsp.quot[DIV_NUM_W-1:WEIGHT_BITS]) ? WMAX :
                                 div_rsp.quot[WEIGHT_BITS-1:0];
                     state_ff <= S_SETW;
                  end
               end

               S_QDIV: begin
                  if (div_rsp.done) begin
                     res_ff.chosen_index <= req_ff.entry_index;
                     res_ff.status       <= STATUS_OK;
                     res_ff.probability  <= (|div_rsp.quot[DIV_NUM_W-1:PROB_FRAC_BITS]) ?
                                            PMAX : div_rsp.quot[PROB_FRAC_BITS-1:0];
                     state_ff            <= S_RESP;
                  end
               end

               // Advance once the result has moved into the output register.
               S_RESP: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     state_ff <= S_IDLE;
                  end
               end

               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/core/wsts_store.sv
// Node weight and subtree total memories with registered read data.
`default_nettype none
module wsts_store
   import wsts_pkg::*;
(
   input  wire logic                   clock,
   input  wire store_cmd_type          cmd,
   output logic [WEIGHT_BITS-1:0]      w_rdata,
   output logic [TOT_W-1:0]            t_rdata
);

   logic [WEIGHT_BITS-1:0] weight_mem [MAX_ENTRIES];
   logic [TOT_W-1:0]       total_mem  [MAX_ENTRIES];
   logic [WEIGHT_BITS-1:0] w_rdata_ff;
   logic [TOT_W-1:0]       t_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.w_we) begin
         weight_mem[cmd.w_waddr] <= cmd.w_wdata;
      end
      w_rdata_ff <= weight_mem[cmd.w_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.t_we) begin
         total_mem[cmd.t_waddr] <= cmd.t_wdata;
      end
      t_rdata_ff <= total_mem[cmd.t_raddr];
   end

   assign w_rdata = w_rdata_ff;
   assign t_rdata = t_rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/core/wsts_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wsts_div
   import wsts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [TOT_W-1:0]     rem_ff;
   logic [TOT_W-1:0]     den_ff;
   logic [TOT_W:0]       rem_sh;
   logic [TOT_W:0]       diff;
   logic                 ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff   = rem_sh - {1'b0, den_ff};
      ge     = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            quo_ff  <= req.num;
            rem_ff  <= '0;
            den_ff  <= req.den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule
`default_nettype wire

FILE: verif/weighted_sum_tree_sampler_core_tb.sv
// Self-checking testbench of the weighted sum-tree sampler core.
`timescale 1ns / 100ps
`default_nettype none
module weighted_sum_tree_sampler_core_tb;
   import wsts_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          DRAIN_WAIT  = 120;
   localparam logic [63:0] PONE        = 64'd1 << PROB_FRAC_BITS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_NUM_ENTRIES;
   logic [15:0] csr_wdata = '0;

   weighted_sum_tree_sampler_core i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the tree and the registers.
   logic [63:0] tree_weight [MAX_ENTRIES];
   logic [63:0] tree_total [MAX_ENTRIES];
   logic [10:0] entries_reg;
   logic [15:0] floor_prob;

   rsp_type pending_rsp [$];
   int      errors = 0;
   int      cycles = 0;
   int      send_idle = 0;
   int      recv_idle = 0;
   int      hold_cycles = 0;

   // ---------------------------------------------------------------- arithmetic
   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // floor(a * b / c), saturating at 64 bits; c is never zero here
   function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] prod;
      logic [127:0] quot;
      prod = {64'd0, a} * {64'd0, b};
      if (prod[127:64] >= c) return '1;
      quot = prod / {64'd0, c};
      return quot[63:0];
   endfunction

   function automatic int active_entries();
      if (entries_reg == 0) return 1;
      if (entries_reg > MAX_ENTRIES) return MAX_ENTRIES;
      return int'(entries_reg);
   endfunction

   function automatic logic [63:0] branch_total(int c, int n);
      return (c < n) ? tree_total[c] : 64'd0;
   endfunction

   // Set one weight and rebuild the totals along the path to the root.
   function automatic void store_weight(int i, logic [63:0] w, int n);
      logic [63:0] t;
      tree_weight[i] = w & {32'd0, WMAX};
      forever begin
         t = add_sat(tree_weight[i], branch_total(2 * i + 1, n));
         tree_total[i] = add_sat(t, branch_total(2 * i + 2, n));
         if (i == 0) break;
         i = (i - 1) / 2;
      end
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         tree_weight[i] = '0;
         tree_total[i] = '0;
      end
   endfunction

   // Apply one word to the shadow tree and return the word it must produce.
   function automatic rsp_type tree_apply(req_type rq);
      rsp_type      r;
      int           n;
      int           i;
      int           idx;
      logic [63:0]  mass, coin, w, wl, wold, rest, p, z, nw, pm;
      logic [127:0] lhs, rhs;
      n = active_entries();
      idx = int'(rq.entry_index);
      mass = tree_total[0];
      r.chosen_index = rq.entry_index;
      r.probability = '0;
      r.status = STATUS_OK;
      if (rq.kind == KIND_SAMPLE) begin
         if (mass == 0) begin
            r.chosen_index = '0;
            r.status = STATUS_OVERRUN;
         end else begin
            coin = scale_div(mass, {48'd0, rq.random_fraction}, PONE);
            i = 0;
            while (2 * i + 1 < n) begin
               w = tree_weight[i];
               wl = add_sat(w, tree_total[2 * i + 1]);
               if (coin < w) break;
               if (coin < wl) begin
                  coin = coin - w;
                  i = 2 * i + 1;
               end else begin
                  coin = coin - wl;
                  if (2 * i + 2 < n) begin
                     i = 2 * i + 2;
                  end else begin
                     r.status = STATUS_OVERRUN;
                     i = 2 * i + 1;
                  end
               end
            end
            r.chosen_index = i[IDX_W-1:0];
         end
      end else if (idx >= n) begin
         r.status = STATUS_RANGE;
      end else if (rq.kind == KIND_LOAD) begin
         store_weight(idx, {32'd0, rq.weight}, n);
      end else if (rq.kind == KIND_PROJECT) begin
         pm = {48'd0, floor_prob};
         wold = tree_weight[idx];
         rest = (mass >= wold) ? mass - wold : 64'd0;
         p = scale_div({48'd0, rq.target_prob}, mass, PONE);
         z = add_sat(rest, p);
         lhs = {64'd0, p} * {64'd0, PONE};
         rhs = {64'd0, pm} * {64'd0, z};
         if (lhs >= rhs) nw = p;
         else nw = scale_div(pm, rest, PONE - pm);
         if (nw > {32'd0, WMAX}) nw = {32'd0, WMAX};
         store_weight(idx, nw, n);
      end else if (mass != 0) begin
         p = scale_div(tree_weight[idx], PONE, mass);
         r.probability = (p > {48'd0, PMAX}) ? PMAX : p[15:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- processes
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("weighted_sum_tree_sampler_core_tb: errors");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is armed.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Check every accepted result word against the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.chosen_index !== exp_rsp.chosen_index) begin
               $display("%0t: chosen_index expected %0d actual %0d", $time,
                        exp_rsp.chosen_index, rsp_data.chosen_index);
               errors++;
            end
            if (rsp_data.probability !== exp_rsp.probability) begin
               $display("%0t: probability expected %0d actual %0d", $time,
                        exp_rsp.probability, rsp_data.probability);
               errors++;
            end
            if (rsp_data.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_rsp.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tasks
   // Offer one word, hold it until taken, then record its expected result.
   task automatic send_word(req_type rq);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(tree_apply(rq));
   endtask

   task automatic send_op(logic [1:0] kind, int idx, logic [31:0] w, logic [15:0] tp,
                          logic [15:0] rf);
      req_type rq;
      rq.kind = kind;
      rq.entry_index = idx[IDX_W-1:0];
      rq.weight = w;
      rq.target_prob = tp;
      rq.random_fraction = rf;
      send_word(rq);
   endtask

   // Drop valid, wait for every expected word, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NUM_ENTRIES) begin
         entries_reg = value[10:0];
         clear_tree();
      end else begin
         floor_prob = value;
      end
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(4))
         0: return '0;
         1: return WMAX;
         2: return $urandom_range(1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_index(int n);
      if ($urandom_range(9) == 0) return $urandom_range(MAX_ENTRIES - 1);
      return $urandom_range(n - 1);
   endfunction

   // Load the first entries (up to 20), then mix every kind of operation.
   task automatic random_phase(int count);
      int          n;
      int          fill;
      logic [15:0] rf;
      n = active_entries();
      fill = (n < 20) ? n : 20;
      for (int k = 0; k < fill; k++) begin
         send_op(KIND_LOAD, k, pick_weight(), 16'($urandom), 16'($urandom));
      end
      for (int k = fill; k < count; k++) begin
         rf = 16'($urandom);
         case ($urandom_range(9))
            0, 1, 2: send_op(KIND_LOAD, pick_index(n), pick_weight(), 16'($urandom), rf);
            3, 4:    send_op(KIND_PROJECT, pick_index(n), $urandom, 16'($urandom), rf);
            5, 6, 7: send_op(KIND_SAMPLE, $urandom, $urandom, 16'($urandom), rf);
            default: send_op(KIND_QUERY, pick_index(n), $urandom, 16'($urandom), rf);
         endcase
      end
   endtask

   // Empty tree, full-scale weights, fraction and probability extremes.
   task automatic test_directed();
      send_op(KIND_QUERY, 0, '0, '0, '0);
      send_op(KIND_SAMPLE, 0, '0, '0, 16'hFFFF);
      send_op(KIND_LOAD, 0, WMAX, '0, '0);
      send_op(KIND_LOAD, MAX_ENTRIES - 1, WMAX, '0, '0);
      send_op(KIND_LOAD, 512, 32'd3, '0, '0);
      send_op(KIND_LOAD, 7, '0, '0, '0);
      send_op(KIND_QUERY, 0, '0, '0, '0);
      send_op(KIND_QUERY, MAX_ENTRIES - 1, '0, '0, '0);
      send_op(KIND_QUERY, 7, '0, '0, '0);
      send_op(KIND_SAMPLE, 0, '0, '0, '0);
      send_op(KIND_SAMPLE, 0, '0, '0, 16'hFFFF);
      send_op(KIND_SAMPLE, 0, '0, '0, 16'h8000);
      send_op(KIND_PROJECT, 512, '0, '0, '0);
      send_op(KIND_PROJECT, 0, '0, 16'hFFFF, '0);
      write_reg(CSR_MIN_PROB, 16'hFFFF);
      send_op(KIND_PROJECT, 512, '0, '0, '0);
      send_op(KIND_PROJECT, 3, '0, 16'h0100, '0);
      send_op(KIND_QUERY, 3, '0, '0, '0);
      // Small tree: indexes at and past the end are rejected.
      write_reg(CSR_NUM_ENTRIES, 16'd5);
      send_op(KIND_LOAD, 5, 32'd9, '0, '0);
      send_op(KIND_PROJECT, MAX_ENTRIES - 1, '0, 16'h4000, '0);
      send_op(KIND_QUERY, 5, '0, '0, '0);
      send_op(KIND_LOAD, 4, 32'd9, '0, '0);
      send_op(KIND_LOAD, 1, 32'd2, '0, '0);
      send_op(KIND_SAMPLE, 0, '0, '0, 16'hFFFF);
      send_op(KIND_QUERY, 4, '0, '0, '0);
   endtask

   task automatic test_register_extremes();
      send_idle = 10;
      recv_idle = 10;
      write_reg(CSR_NUM_ENTRIES, 16'd0);
      write_reg(CSR_MIN_PROB, 16'd0);
      random_phase(15);
      write_reg(CSR_NUM_ENTRIES, 16'h07FF);
      write_reg(CSR_MIN_PROB, 16'hFFFF);
      random_phase(40);
      write_reg(CSR_NUM_ENTRIES, 16'd1024);
      random_phase(40);
   endtask

   task automatic test_random_traffic();
      int idle_pairs [3][2] = '{'{23, 86}, '{86, 23}, '{0, 0}};
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = idle_pairs[ph][0];
         recv_idle = idle_pairs[ph][1];
         write_reg(CSR_NUM_ENTRIES, 16'($urandom_range(1, 40)));
         write_reg(CSR_MIN_PROB, 16'($urandom_range(0, 65535)));
         random_phase(90);
      end
   endtask

   // Stall the result side long enough that the block backs up its input.
   task automatic test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      write_reg(CSR_NUM_ENTRIES, 16'd31);
      random_phase(20);
      drain();
      hold_cycles <= 500;
      random_phase(12);
   endtask

   initial begin
      clear_tree();
      entries_reg = 11'd1024;
      floor_prob = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();
      drain();
      if (errors == 0) begin
         $display("weighted_sum_tree_sampler_core_tb: clean");
      end else begin
         $display("weighted_sum_tree_sampler_core_tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: weighted_sum_tree_sampler_core.f
rtl/core/wsts_pkg.sv
rtl/core/wsts_store.sv
rtl/core/wsts_div.sv
rtl/core/weighted_sum_tree_sampler_core.sv
verif/weighted_sum_tree_sampler_core_tb.sv
